// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked on the following edge
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rhht_pkg.sv
// types and codes shared by the robin hood hash table modules
// no dependencies
`default_nettype none

package rhht_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 10;

  typedef enum logic [1:0] {
    KIND_FIND   = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // one stored slot
  typedef struct packed {
    logic [WORD_W-1:0] hash;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } entry_t;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_CLR_STEP,
    CMD_PROBE_NEXT,
    CMD_FIND_HIT,
    CMD_PUT_HIT,
    CMD_PUT_FULL,
    CMD_PUT_START,
    CMD_EMP_SWAP,
    CMD_EMP_SKIP,
    CMD_RM_HIT,
    CMD_SHIFT_MOVE,
    CMD_SHIFT_END,
    CMD_EMIT
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  match;
    logic  poorer;
    logic  disp_zero;
    logic  full_cond;
    logic  clr_last;
    logic  out_free;
  } status_t;

  typedef enum logic [8:0] {
    S_RST_CLR = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_OP_CLR  = 9'b000000100,
    S_LRD     = 9'b000001000,
    S_LEV     = 9'b000010000,
    S_ERD     = 9'b000100000,
    S_EEV     = 9'b001000000,
    S_SHIFT   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// File: src/rhht_datapath.sv
// slot memory, probe index, carried entry, counters and output register
// depends on rhht_pkg
`default_nettype none

module rhht_datapath #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rhht_pkg::cmd_t                cmd,
  output rhht_pkg::status_t                  status,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [rhht_pkg::WORD_W-1:0]   in_key,
  input  wire logic [rhht_pkg::WORD_W-1:0]   in_hash,
  input  wire logic [rhht_pkg::WORD_W-1:0]   in_value,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rhht_pkg::COUNT_W-1:0]  cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic                               out_created,
  output logic                               out_full_res,
  output logic [rhht_pkg::WORD_W-1:0]        out_value_out,
  output logic [rhht_pkg::COUNT_W-1:0]       out_occupancy
);

  localparam int unsigned IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CAP_I   = (SLOTS - 1 > 1023) ? 1023 : SLOTS - 1;
  localparam int unsigned DEF_RAW = (SLOTS * 95) / 100;
  localparam int unsigned DEF_I   = (DEF_RAW > CAP_I) ? CAP_I : DEF_RAW;
  localparam logic [rhht_pkg::COUNT_W-1:0] CAP = rhht_pkg::COUNT_W'(CAP_I);
  localparam logic [rhht_pkg::COUNT_W-1:0] DEF = rhht_pkg::COUNT_W'(DEF_I);

  rhht_pkg::entry_t mem [SLOTS];
  rhht_pkg::entry_t rdata_r;

  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] dist_r, dist_nxt;
  rhht_pkg::kind_t kind_r, kind_nxt;
  logic [rhht_pkg::WORD_W-1:0] h_r, h_nxt, key_r, key_nxt, val_r, val_nxt;
  logic [rhht_pkg::COUNT_W-1:0] count_r, count_nxt, max_load_r, limit;
  logic found_r, found_nxt, created_r, created_nxt, full_r, full_nxt;
  logic [rhht_pkg::WORD_W-1:0] vout_r, vout_nxt;
  logic out_valid_r;
  logic out_found_r, out_created_r, out_full_r;
  logic [rhht_pkg::WORD_W-1:0] out_vout_r;
  logic [rhht_pkg::COUNT_W-1:0] out_count_r;

  logic we;
  logic [IW-1:0] waddr;
  rhht_pkg::entry_t wdata;
  logic [IW-1:0] disp;
  logic [IW-1:0] idx_prev;

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[idx_r];
  end

  // probe evaluation
  assign disp     = idx_r - rdata_r.hash[IW-1:0];
  assign idx_prev = idx_r - IW'(1);
  assign limit    = (max_load_r > CAP) ? CAP : max_load_r;

  always_comb begin
    status.kind      = kind_r;
    status.empty     = (rdata_r.hash == '0);
    status.match     = (rdata_r.hash == h_r) && (rdata_r.key == key_r);
    status.poorer    = (disp < dist_r);
    status.disp_zero = (disp == '0);
    status.full_cond = (count_r >= limit);
    status.clr_last  = (idx_r == '1);
    status.out_free  = !out_valid_r || out_ready;
  end

  // write port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = '{hash: h_r, key: key_r, value: val_r};
    case (cmd)
      rhht_pkg::CMD_CLR_STEP: begin
        we         = 1'b1;
        wdata.hash = '0;
      end
      rhht_pkg::CMD_PUT_HIT, rhht_pkg::CMD_EMP_SWAP: begin
        we = 1'b1;
      end
      rhht_pkg::CMD_SHIFT_MOVE: begin
        we    = 1'b1;
        waddr = idx_prev;
        wdata = rdata_r;
      end
      rhht_pkg::CMD_SHIFT_END: begin
        we         = 1'b1;
        waddr      = idx_prev;
        wdata      = rdata_r;
        wdata.hash = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // working registers
  always_comb begin
    idx_nxt     = idx_r;
    dist_nxt    = dist_r;
    kind_nxt    = kind_r;
    h_nxt       = h_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    found_nxt   = found_r;
    created_nxt = created_r;
    full_nxt    = full_r;
    vout_nxt    = vout_r;
    case (cmd)
      rhht_pkg::CMD_LOAD: begin
        kind_nxt    = rhht_pkg::kind_t'(in_kind);
        h_nxt       = (in_hash == '0) ? rhht_pkg::WORD_W'(1) : in_hash;
        key_nxt     = in_key;
        val_nxt     = in_value;
        idx_nxt     = (in_kind == rhht_pkg::KIND_CLEAR) ? '0 : h_nxt[IW-1:0];
        dist_nxt    = '0;
        found_nxt   = 1'b0;
        created_nxt = 1'b0;
        full_nxt    = 1'b0;
        vout_nxt    = '0;
        if (in_kind == rhht_pkg::KIND_CLEAR) begin
          count_nxt = '0;
        end
      end
      rhht_pkg::CMD_CLR_STEP: begin
        idx_nxt = idx_r + IW'(1);
      end
      rhht_pkg::CMD_PROBE_NEXT, rhht_pkg::CMD_EMP_SKIP: begin
        idx_nxt  = idx_r + IW'(1);
        dist_nxt = dist_r + IW'(1);
      end
      rhht_pkg::CMD_FIND_HIT: begin
        found_nxt = 1'b1;
        vout_nxt  = rdata_r.value;
      end
      rhht_pkg::CMD_PUT_HIT: begin
        found_nxt = 1'b1;
      end
      rhht_pkg::CMD_PUT_FULL: begin
        full_nxt = 1'b1;
      end
      rhht_pkg::CMD_PUT_START: begin
        created_nxt = 1'b1;
        count_nxt   = count_r + rhht_pkg::COUNT_W'(1);
      end
      rhht_pkg::CMD_EMP_SWAP: begin
        h_nxt    = rdata_r.hash;
        key_nxt  = rdata_r.key;
        val_nxt  = rdata_r.value;
        dist_nxt = disp + IW'(1);
        idx_nxt  = idx_r + IW'(1);
      end
      rhht_pkg::CMD_RM_HIT: begin
        found_nxt = 1'b1;
        vout_nxt  = rdata_r.value;
        if (count_r != '0) begin
          count_nxt = count_r - rhht_pkg::COUNT_W'(1);
        end
        idx_nxt = idx_r + IW'(1);
      end
      rhht_pkg::CMD_SHIFT_MOVE: begin
        idx_nxt = idx_r + IW'(1);
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      count_r    <= '0;
      max_load_r <= DEF;
    end else begin
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      if (cfg_valid) begin
        max_load_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r    <= dist_nxt;
    kind_r    <= kind_nxt;
    h_r       <= h_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    found_r   <= found_nxt;
    created_r <= created_nxt;
    full_r    <= full_nxt;
    vout_r    <= vout_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == rhht_pkg::CMD_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == rhht_pkg::CMD_EMIT) begin
      out_found_r   <= found_r;
      out_created_r <= created_r;
      out_full_r    <= full_r;
      out_vout_r    <= vout_r;
      out_count_r   <= count_r;
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_created   = out_created_r;
  assign out_full_res  = out_full_r;
  assign out_value_out = out_vout_r;
  assign out_occupancy = out_count_r;

endmodule

`default_nettype wire

// File: src/rhht_ctrl.sv
// controller state machine sequencing probe, insert, shift and clear
// depends on rhht_pkg
`default_nettype none

module rhht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rhht_pkg::status_t status,
  output rhht_pkg::cmd_t         cmd
);

  rhht_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhht_pkg::S_RST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == rhht_pkg::S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = rhht_pkg::CMD_NOP;
    case (state_r)
      rhht_pkg::S_RST_CLR: begin
        cmd = rhht_pkg::CMD_CLR_STEP;
        if (status.clr_last) begin
          state_nxt = rhht_pkg::S_IDLE;
        end
      end
      rhht_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd = rhht_pkg::CMD_LOAD;
          state_nxt = rhht_pkg::S_LRD;
        end
      end
      rhht_pkg::S_LRD: begin
        // clear is decided here, after the item kind is latched
        if (status.kind == rhht_pkg::KIND_CLEAR) begin
          state_nxt = rhht_pkg::S_OP_CLR;
        end else begin
          state_nxt = rhht_pkg::S_LEV;
        end
      end
      rhht_pkg::S_OP_CLR: begin
        cmd = rhht_pkg::CMD_CLR_STEP;
        if (status.clr_last) begin
          state_nxt = rhht_pkg::S_DONE;
        end
      end
      rhht_pkg::S_LEV: begin
        if (!status.empty && status.match) begin
          case (status.kind)
            rhht_pkg::KIND_FIND: begin
              cmd = rhht_pkg::CMD_FIND_HIT;
              state_nxt = rhht_pkg::S_DONE;
            end
            rhht_pkg::KIND_PUT: begin
              cmd = rhht_pkg::CMD_PUT_HIT;
              state_nxt = rhht_pkg::S_DONE;
            end
            default: begin
              cmd = rhht_pkg::CMD_RM_HIT;
              state_nxt = rhht_pkg::S_SHIFT;
            end
          endcase
        end else if (status.empty || status.poorer) begin
          // key absent
          if (status.kind == rhht_pkg::KIND_PUT) begin
            if (status.full_cond) begin
              cmd = rhht_pkg::CMD_PUT_FULL;
              state_nxt = rhht_pkg::S_DONE;
            end else begin
              cmd = rhht_pkg::CMD_PUT_START;
              state_nxt = rhht_pkg::S_ERD;
            end
          end else begin
            state_nxt = rhht_pkg::S_DONE;
          end
        end else begin
          cmd = rhht_pkg::CMD_PROBE_NEXT;
          state_nxt = rhht_pkg::S_LRD;
        end
      end
      rhht_pkg::S_ERD: begin
        state_nxt = rhht_pkg::S_EEV;
      end
      rhht_pkg::S_EEV: begin
        if (status.empty || status.poorer) begin
          cmd = rhht_pkg::CMD_EMP_SWAP;
          state_nxt = status.empty ? rhht_pkg::S_DONE : rhht_pkg::S_ERD;
        end else begin
          cmd = rhht_pkg::CMD_EMP_SKIP;
          state_nxt = rhht_pkg::S_ERD;
        end
      end
      rhht_pkg::S_SHIFT: begin
        // read of the next slot is in flight this cycle
        state_nxt = rhht_pkg::S_ERD;
      end
      rhht_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd = rhht_pkg::CMD_EMIT;
          state_nxt = rhht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rhht_pkg::S_IDLE;
      end
    endcase
    // backward shift evaluation shares the evaluate state with emplace
    if (state_r == rhht_pkg::S_EEV && status.kind == rhht_pkg::KIND_REMOVE) begin
      if (status.empty || status.disp_zero) begin
        cmd = rhht_pkg::CMD_SHIFT_END;
        state_nxt = rhht_pkg::S_DONE;
      end else begin
        cmd = rhht_pkg::CMD_SHIFT_MOVE;
        state_nxt = rhht_pkg::S_ERD;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/robin_hood_hash_table.sv
// robin hood hash table on SLOTS slots; depends on rhht_pkg, rhht_ctrl, rhht_datapath
// one item at a time: the next is taken the cycle after the result is emitted, and a
// result held by the receiver stalls the table until it is taken
// reset: the block sweeps the memory, emptying every slot, with in_ready low
`default_nettype none

module robin_hood_hash_table #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [rhht_pkg::WORD_W-1:0]   in_key,
  input  wire logic [rhht_pkg::WORD_W-1:0]   in_hash,
  input  wire logic [rhht_pkg::WORD_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic                               out_created,
  output logic                               out_full_res,
  output logic [rhht_pkg::WORD_W-1:0]        out_value_out,
  output logic [rhht_pkg::COUNT_W-1:0]       out_occupancy,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rhht_pkg::COUNT_W-1:0]  cfg_data
);

  rhht_pkg::cmd_t    cmd;
  rhht_pkg::status_t status;

  rhht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rhht_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_kind       (in_kind),
    .in_key        (in_key),
    .in_hash       (in_hash),
    .in_value      (in_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_created   (out_created),
    .out_full_res  (out_full_res),
    .out_value_out (out_value_out),
    .out_occupancy (out_occupancy)
  );

endmodule

`default_nettype wire

// File: src/rhht_checker.sv
// port-level checks on the hash table result channel, bound to the top level
// depends on assert_macros.svh and rhht_pkg
`default_nettype none
`include "assert_macros.svh"

module rhht_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_found,
  input wire logic                          out_created,
  input wire logic                          out_full_res,
  input wire logic [rhht_pkg::WORD_W-1:0]   out_value_out,
  input wire logic [rhht_pkg::COUNT_W-1:0]  out_occupancy
);

  // a new entry means the key was absent and there was room
  `CHK_ALWAYS(a_created_excl, clk, rst_n, !(out_valid && out_created) || (!out_found && !out_full_res), "created with found or full")
  // a refused put found nothing and returns no value
  `CHK_ALWAYS(a_full_excl, clk, rst_n, !(out_valid && out_full_res) || (!out_found && out_value_out == '0), "full with found or value")
  // a nonzero value only comes with a hit, and a creation leaves entries
  `CHK_ALWAYS(a_value_hit, clk, rst_n, !(out_valid && (out_value_out != '0)) || out_found, "value without hit")
  `CHK_ALWAYS(a_created_count, clk, rst_n, !(out_valid && out_created) || (out_occupancy != '0), "created with zero count")
  // stalled item holds
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value_out), "result dropped under stall")

endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_found     (out_found),
  .out_created   (out_created),
  .out_full_res  (out_full_res),
  .out_value_out (out_value_out),
  .out_occupancy (out_occupancy)
);

`default_nettype wire

// File: dv/robin_hood_hash_table_test.sv
// self-checking testbench for the robin hood hash table: directed and random items
// with a scoreboard class holding its own copy of the slot table and load limit
// depends on rhht_pkg and robin_hood_hash_table
`timescale 1ns / 100ps

module robin_hood_hash_table_test;

  localparam int unsigned NSLOTS = 1024;
  localparam int unsigned QUIET_LIMIT = 40000;

  typedef struct packed {
    bit        found;
    bit        created;
    bit        full_res;
    bit [63:0] value_out;
    bit [9:0]  occupancy;
  } outcome_t;

  // table predictor and store of expected outcomes
  class table_scoreboard;
    bit [63:0] tbl_hash [NSLOTS];
    bit [63:0] tbl_key [NSLOTS];
    bit [63:0] tbl_val [NSLOTS];
    int unsigned n_entries;
    int unsigned load_limit;
    outcome_t pending_q[$];
    int unsigned mismatches;

    function new();
      foreach (tbl_hash[i]) begin
        tbl_hash[i] = '0;
        tbl_key[i] = '0;
        tbl_val[i] = '0;
      end
      n_entries = 0;
      load_limit = 972;
      mismatches = 0;
    endfunction

    function void set_limit(int unsigned v);
      load_limit = v;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function bit [9:0] disp(bit [9:0] slot, bit [63:0] h);
      return slot - h[9:0];
    endfunction

    // probe from the home slot; stops on empty, match or a richer entry
    function bit lookup(bit [63:0] h, bit [63:0] k, output bit [9:0] slot,
                        output int unsigned pdist);
      bit [9:0] i;
      slot = 0;
      pdist = 0;
      for (int unsigned p = 0; p < NSLOTS; p++) begin
        i = h[9:0] + p[9:0];
        slot = i;
        pdist = p;
        if (tbl_hash[i] == 0) return 0;
        if (tbl_hash[i] == h && tbl_key[i] == k) return 1;
        if (disp(i, tbl_hash[i]) < p) return 0;
      end
      return 0;
    endfunction

    // insert, swapping with entries closer to their home
    function void insert(bit [63:0] h, bit [63:0] k, bit [63:0] v, int unsigned p);
      bit [9:0] i;
      bit [63:0] oh, ok, ov;
      int unsigned od;
      for (int unsigned s = 0; s <= NSLOTS && h != 0; s++) begin
        i = h[9:0] + p[9:0];
        oh = tbl_hash[i];
        od = disp(i, oh);
        if (oh == 0 || od < p) begin
          ok = tbl_key[i];
          ov = tbl_val[i];
          tbl_hash[i] = h;
          tbl_key[i] = k;
          tbl_val[i] = v;
          h = oh;
          k = ok;
          v = ov;
          p = od + 1;
        end else begin
          p++;
        end
      end
    endfunction

    // close the gap left by a removed entry
    function void shift_back(bit [9:0] i);
      bit [9:0] n;
      for (int unsigned s = 0; s < NSLOTS; s++) begin
        n = i + 10'd1;
        if (tbl_hash[n] == 0) break;
        if (tbl_hash[n][9:0] == n) break;
        tbl_hash[i] = tbl_hash[n];
        tbl_key[i] = tbl_key[n];
        tbl_val[i] = tbl_val[n];
        i = n;
      end
      tbl_hash[i] = 0;
      tbl_key[i] = 0;
      tbl_val[i] = 0;
    endfunction

    // an accepted item: update the table copy and queue the outcome
    function void note_item(rhht_pkg::kind_t kind, bit [63:0] k, bit [63:0] h_in,
                            bit [63:0] v);
      outcome_t o;
      bit [63:0] h;
      bit [9:0] slot;
      int unsigned pdist;
      int unsigned lim;
      bit hit;
      h = (h_in == 0) ? 64'd1 : h_in;
      lim = (load_limit > NSLOTS - 1) ? NSLOTS - 1 : load_limit;
      o = '{0, 0, 0, 64'd0, 10'd0};
      if (kind == rhht_pkg::KIND_CLEAR) begin
        foreach (tbl_hash[i]) tbl_hash[i] = '0;
        n_entries = 0;
      end else begin
        hit = lookup(h, k, slot, pdist);
        o.found = hit;
        case (kind)
          rhht_pkg::KIND_FIND: begin
            if (hit) o.value_out = tbl_val[slot];
          end
          rhht_pkg::KIND_PUT: begin
            if (hit) tbl_val[slot] = v;
            else if (n_entries + 1 > lim) o.full_res = 1;
            else begin
              n_entries++;
              insert(h, k, v, pdist);
              o.created = 1;
            end
          end
          default: begin
            if (hit) begin
              o.value_out = tbl_val[slot];
              if (n_entries > 0) n_entries--;
              shift_back(slot);
            end
          end
        endcase
      end
      o.occupancy = n_entries[9:0];
      pending_q.push_back(o);
    endfunction

    // compare one result item with the oldest outcome
    function void check_result(outcome_t got);
      outcome_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected");
        return;
      end
      e = pending_q.pop_front();
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp f%0b c%0b x%0b v%h n%0d got f%0b c%0b x%0b v%h n%0d",
                   e.found, e.created, e.full_res, e.value_out, e.occupancy,
                   got.found, got.created, got.full_res, got.value_out, got.occupancy);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_kind;
  logic [63:0] in_key, in_hash, in_value;
  logic out_valid, out_ready;
  logic out_found, out_created, out_full_res;
  logic [63:0] out_value_out;
  logic [9:0] out_occupancy;
  logic cfg_valid, cfg_ready;
  logic [9:0] cfg_data;

  table_scoreboard sb;
  bit idling_on;
  bit hold_request;
  int unsigned quiet_cycles;

  // key pool with fixed hashes clustered around the wrap of the slot index
  bit [63:0] pool_key [48];
  bit [63:0] pool_hash [48];

  robin_hood_hash_table #(.SLOTS(NSLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_key(in_key), .in_hash(in_hash), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_found(out_found), .out_created(out_created), .out_full_res(out_full_res),
    .out_value_out(out_value_out), .out_occupancy(out_occupancy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: check each result item, then stall in bursts or a long hold
  int unsigned stall_left;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_found, out_created, out_full_res, out_value_out,
                        out_occupancy});
    if (hold_request) begin
      hold_request = 0;
      stall_left = 300;
    end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(rhht_pkg::kind_t kind, bit [63:0] k, bit [63:0] h,
                           bit [63:0] v);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= k;
    in_hash <= h;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_item(kind, k, h, v);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // load limit is written only with the table idle
  task automatic write_limit(bit [9:0] v);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  // well-formed traffic on the key pool, with some off-pool noise
  task automatic random_items(int unsigned n, int unsigned put_pct);
    rhht_pkg::kind_t kind;
    int unsigned r, j;
    bit [63:0] k, h;
    for (int unsigned t = 0; t < n; t++) begin
      r = $urandom_range(0, 99);
      if (r < 1) kind = rhht_pkg::KIND_CLEAR;
      else if (r < 1 + put_pct) kind = rhht_pkg::KIND_PUT;
      else if (r < 60 + put_pct / 2) kind = rhht_pkg::KIND_FIND;
      else kind = rhht_pkg::KIND_REMOVE;
      j = $urandom_range(0, 47);
      k = pool_key[j];
      h = pool_hash[j];
      if ($urandom_range(0, 9) == 0) begin
        k = {$urandom, $urandom};
        h = {$urandom, $urandom};
      end else if ($urandom_range(0, 19) == 0) begin
        h = {$urandom, h[31:0]};
      end
      send_item(kind, k, h, {$urandom, $urandom});
    end
  endtask

  initial begin
    sb = new();
    idling_on = 1;
    hold_request = 0;
    stall_left = 0;
    quiet_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= rhht_pkg::KIND_FIND;
    in_key <= '0;
    in_hash <= '0;
    in_value <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    out_ready <= 1'b0;
    foreach (pool_key[i]) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = {$urandom, $urandom} & ~64'h3ff;
      pool_hash[i][9:0] = 10'd1016 + 10'($urandom_range(0, 15));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, hash zero, replace, wrap, collisions, extremes
    send_item(rhht_pkg::KIND_FIND, 64'd5, 64'd5, 64'd0);
    send_item(rhht_pkg::KIND_PUT, 64'd0, 64'd0, '1);
    send_item(rhht_pkg::KIND_FIND, 64'd0, 64'd1, 64'd0);
    send_item(rhht_pkg::KIND_PUT, 64'd0, 64'd1, 64'h1234);
    send_item(rhht_pkg::KIND_FIND, 64'd0, 64'd0, 64'd0);
    send_item(rhht_pkg::KIND_PUT, '1, '1, '1);
    send_item(rhht_pkg::KIND_PUT, 64'd7, 64'h3ff, 64'd70);
    send_item(rhht_pkg::KIND_PUT, 64'd8, 64'h7ff, 64'd80);
    send_item(rhht_pkg::KIND_PUT, 64'd9, 64'h400, 64'd90);
    send_item(rhht_pkg::KIND_FIND, 64'd8, 64'h7ff, 64'd0);
    send_item(rhht_pkg::KIND_REMOVE, 64'd3, 64'h3ff, 64'd0);
    send_item(rhht_pkg::KIND_REMOVE, '1, '1, 64'd0);
    send_item(rhht_pkg::KIND_FIND, 64'd9, 64'h400, 64'd0);
    send_item(rhht_pkg::KIND_REMOVE, 64'd7, 64'h3ff, 64'd0);
    send_item(rhht_pkg::KIND_FIND, 64'd8, 64'h7ff, 64'd0);
    send_item(rhht_pkg::KIND_CLEAR, '1, '1, '1);
    send_item(rhht_pkg::KIND_FIND, 64'd9, 64'h400, 64'd0);

    // load limit extremes: small, zero, largest
    write_limit(10'd2);
    send_item(rhht_pkg::KIND_PUT, 64'd1, 64'd1, 64'd11);
    send_item(rhht_pkg::KIND_PUT, 64'd2, 64'd1, 64'd22);
    send_item(rhht_pkg::KIND_PUT, 64'd3, 64'd2, 64'd33);
    send_item(rhht_pkg::KIND_PUT, 64'd2, 64'd1, 64'd44);
    write_limit(10'd0);
    send_item(rhht_pkg::KIND_PUT, 64'd4, 64'd4, 64'd4);
    send_item(rhht_pkg::KIND_REMOVE, 64'd1, 64'd1, 64'd0);
    write_limit(10'h3ff);

    // random, with a long receiver hold and a sender pause
    random_items(120, 45);
    hold_request = 1;
    random_items(80, 45);
    drain();
    random_items(120, 40);
    write_limit(10'd5);
    random_items(140, 40);
    write_limit(10'd972);
    idling_on = 0;
    random_items(180, 40);

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
